// ===== design/kti_pkg.sv =====
// Shared types and constants for the keyframe track interpolator.
package kti_pkg;

    // Key indexes are carried at the width of the largest supported track.
    localparam int unsigned IDX_W = 10;
    localparam int unsigned FRAC_ONE = 65536;

    typedef enum logic [1:0] {
        REG_FRAME_COUNT   = 2'd0,
        REG_CLIP_DURATION = 2'd1,
        REG_START_OFFSET  = 2'd2
    } reg_idx_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [31:0]        ktime;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } entry_t;

    // Search token that moves one cell per cycle down the key chain.
    typedef struct packed {
        logic              valid;
        logic [31:0]       q;
        logic [31:0]       so;
        logic              found;
        logic [IDX_W-1:0]  f;
        entry_t            prev_e;
        entry_t            next_e;
        entry_t            last_e;
        logic              so_found;
        logic [IDX_W-1:0]  so_idx;
        entry_t            so_e;
        entry_t            e0;
    } token_t;

endpackage

// ===== design/kti_cell.sv =====
// One keyframe cell: holds one key and updates the passing search token.
module kti_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  kti_pkg::entry_t            wr_entry,
    input  logic [kti_pkg::IDX_W-1:0]  last_idx,
    input  kti_pkg::token_t            tok_in,
    output kti_pkg::token_t            tok_out
);
    import kti_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    entry_t entry_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   in_range;

    assign in_range = (MY_IDX <= last_idx);

    always_comb
    begin
        tok_next        = tok_in;
        tok_next.last_e = entry_reg;
        if (MY_IDX == '0)
        begin
            tok_next.e0 = entry_reg;
        end
        if (!tok_in.found && in_range &&
            ((entry_reg.ktime > tok_in.q) || (MY_IDX == last_idx)))
        begin
            tok_next.found  = 1'b1;
            tok_next.f      = MY_IDX;
            tok_next.next_e = entry_reg;
            tok_next.prev_e = (MY_IDX == '0) ? entry_reg : tok_in.last_e;
        end
        if (!tok_in.so_found && in_range &&
            ((entry_reg.ktime > tok_in.so) || (MY_IDX == last_idx)))
        begin
            tok_next.so_found = 1'b1;
            tok_next.so_idx   = MY_IDX;
            tok_next.so_e     = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/kti_divider.sv =====
// Restoring divider giving a 16-bit fraction of two 32-bit values, one bit a cycle.
module kti_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import kti_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [15:0] quo_reg, quo_next;
    logic [32:0] shifted;

    assign shifted = {rem_reg, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = 32'(shifted - {1'b0, div_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && (cnt_reg == 5'd15);
    assign quotient = quo_next;

endmodule

// ===== design/keyframe_track_interpolator.sv =====
// Top level of the keyframe track interpolator.
//
// Items arrive on the s_ stream. s_tuser carries the command: a write stores
// one keyframe into its cell of the key chain, a query evaluates the track.
// Writes produce no transfer on the m_ stream. A query produces exactly one
// transfer carrying the interpolated x, y and z, the fraction, both
// bracketing key indexes and the wrap flag.
// A query token walks the chain of MAX_KEYS cells, one cell per cycle. The
// fraction is then set directly, or by the 16-step serial divider when a
// true division is needed, and the three lerps share one multiplier. One
// query is worked on at a time. The result waits in an output register, so a
// new item can be accepted while the receiver stalls; a second query's result
// waits for that register. Configuration writes on cfg_we go straight to the
// registers; the user must see that they are made only while the block is
// idle, as the block itself does not enforce it. Reset clears control state
// and sets a frame count of one; key storage is undefined until written.
module keyframe_track_interpolator #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // Fields from bit 0 up: key_index, key_time, value_x, value_y, value_z,
    // query_time, zero fill.
    input  logic [167:0]  s_tdata,
    // Fields: cmd.
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // Fields from bit 0 up: out_x, out_y, out_z, fraction, prev_index,
    // next_index, wrapped, zero fill.
    output logic [127:0]  m_tdata,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import kti_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_FRAC   = 6'b000100,
        S_DIV    = 6'b001000,
        S_MUL    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  frame_count_reg;
    logic [31:0] clip_duration_reg;
    logic [31:0] start_offset_reg;

    // Input field unpacking.
    logic [5:0]  key_index;
    logic [31:0] key_time, query_time;
    logic [31:0] value_x, value_y, value_z;
    logic        in_accept;
    logic        cmd_write;

    assign key_index  = s_tdata[5:0];
    assign key_time   = s_tdata[37:6];
    assign value_x    = s_tdata[69:38];
    assign value_y    = s_tdata[101:70];
    assign value_z    = s_tdata[133:102];
    assign query_time = s_tdata[165:134];
    assign in_accept  = s_tvalid && s_tready;
    assign cmd_write  = (s_tuser == CMD_WRITE);

    // Clamp the key count to 1..MAX_KEYS and form the last index.
    logic [IDX_W-1:0] last_idx;
    always_comb
    begin
        if (frame_count_reg == 7'd0)
        begin
            last_idx = '0;
        end
        else if (32'(frame_count_reg) > MAX_KEYS)
        begin
            last_idx = IDX_W'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = IDX_W'(frame_count_reg - 7'd1);
        end
    end

    // Key chain.
    entry_t wr_entry;
    token_t tok [MAX_KEYS+1];

    assign wr_entry.ktime = key_time;
    assign wr_entry.x     = value_x;
    assign wr_entry.y     = value_y;
    assign wr_entry.z     = value_z;

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = in_accept && !cmd_write;
        tok[0].q     = query_time;
        tok[0].so    = start_offset_reg;
    end

    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_cell
        kti_cell #(
            .IDX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (in_accept && cmd_write && (32'(key_index) == 32'(i))),
            .wr_entry (wr_entry),
            .last_idx (last_idx),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    token_t tail;
    assign tail = tok[MAX_KEYS];

    // Bracket selection from the finished token.
    logic               wrap_c;
    entry_t             prev_c, next_c;
    logic [IDX_W-1:0]   prev_i_c, next_i_c;
    logic signed [32:0] span_c, elapsed_c;

    always_comb
    begin
        wrap_c = (tail.f == last_idx) && (tail.next_e.ktime <= tail.q);
        if (wrap_c)
        begin
            prev_c   = tail.next_e;
            prev_i_c = tail.f;
            if (tail.so != 32'd0)
            begin
                next_c   = tail.so_e;
                next_i_c = tail.so_idx;
            end
            else
            begin
                next_c   = tail.e0;
                next_i_c = '0;
            end
            span_c = $signed({1'b0, clip_duration_reg}) - $signed({1'b0, prev_c.ktime});
        end
        else
        begin
            prev_c   = tail.prev_e;
            prev_i_c = (tail.f == '0) ? '0 : tail.f - IDX_W'(1);
            next_c   = tail.next_e;
            next_i_c = tail.f;
            span_c   = $signed({1'b0, next_c.ktime}) - $signed({1'b0, prev_c.ktime});
        end
        elapsed_c = $signed({1'b0, tail.q}) - $signed({1'b0, prev_c.ktime});
    end

    entry_t             prev_reg, next_reg;
    logic [IDX_W-1:0]   prev_i_reg, next_i_reg;
    logic               wrap_reg;
    logic signed [32:0] span_reg, elapsed_reg;
    logic [16:0]        frac_reg, frac_next;
    logic [1:0]         mul_cnt_reg, mul_cnt_next;
    logic [31:0]        res_reg [3];

    // Fraction divider.
    logic        div_start, div_done;
    logic [15:0] div_quo;

    assign div_start = (state_reg == S_FRAC) && !(span_reg <= 0 || elapsed_reg >= span_reg)
                       && !(elapsed_reg <= 0);

    kti_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg[31:0]),
        .divisor  (span_reg[31:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Shared lerp multiplier, one component per cycle.
    logic signed [31:0] mul_a, mul_b;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic [31:0]        lerp_res;

    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:
            begin
                mul_a = prev_reg.x;
                mul_b = next_reg.x;
            end
            2'd1:
            begin
                mul_a = prev_reg.y;
                mul_b = next_reg.y;
            end
            default:
            begin
                mul_a = prev_reg.z;
                mul_b = next_reg.z;
            end
        endcase
        diff     = 33'(mul_b) - 33'(mul_a);
        prod     = 51'(diff) * $signed({34'd0, frac_reg});
        lerp_res = 32'(mul_a + 32'(prod >>> 16));
    end

    // Output register.
    logic         m_tvalid_reg, m_tvalid_next;
    logic [127:0] m_tdata_reg;
    logic         out_load;

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        frac_next     = frac_reg;
        mul_cnt_next  = mul_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !cmd_write)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tail.valid)
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                mul_cnt_next = 2'd0;
                if (span_reg <= 0 || elapsed_reg >= span_reg)
                begin
                    frac_next  = 17'(FRAC_ONE);
                    state_next = S_MUL;
                end
                else if (elapsed_reg <= 0)
                begin
                    frac_next  = 17'd0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    frac_next  = {1'b0, div_quo};
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            m_tvalid_reg      <= 1'b0;
            mul_cnt_reg       <= '0;
            frame_count_reg   <= 7'd1;
            clip_duration_reg <= '0;
            start_offset_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            mul_cnt_reg  <= mul_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_COUNT:   frame_count_reg   <= cfg_data[6:0];
                    REG_CLIP_DURATION: clip_duration_reg <= cfg_data;
                    REG_START_OFFSET:  start_offset_reg  <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        if (state_reg == S_SEARCH && tail.valid)
        begin
            prev_reg    <= prev_c;
            next_reg    <= next_c;
            prev_i_reg  <= prev_i_c;
            next_i_reg  <= next_i_c;
            wrap_reg    <= wrap_c;
            span_reg    <= span_c;
            elapsed_reg <= elapsed_c;
        end
        if (state_reg == S_MUL)
        begin
            res_reg[mul_cnt_reg] <= lerp_res;
        end
        if (out_load)
        begin
            m_tdata_reg <= {2'd0, wrap_reg, 6'(next_i_reg), 6'(prev_i_reg), frac_reg,
                            res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A query token leaves the chain only while the controller waits for it.
    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == S_SEARCH))
        else $error("search token left the chain outside the search state");

    // The divider finishes only while the controller waits on it.
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // A freshly loaded result is never a value that overwrote a stalled one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !out_load)
        else $error("result register loaded while a result was stalled");

    // The fraction never exceeds one.
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (frac_reg <= 17'(FRAC_ONE)))
        else $error("fraction above one");

endmodule

// ===== dv/kti_checker.sv =====
// Checker for the keyframe track interpolator: watches the streams, predicts results and compares.
module kti_checker #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kti_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        frac;
        logic [5:0]         prev_idx;
        logic [5:0]         next_idx;
        logic               wrapped;
    } interp_t;

    // Shadow copy of the track and the registers.
    logic [31:0]        trk_time [MAX_KEYS];
    logic signed [31:0] trk_x [MAX_KEYS];
    logic signed [31:0] trk_y [MAX_KEYS];
    logic signed [31:0] trk_z [MAX_KEYS];
    logic [6:0]         frame_count;
    logic [31:0]        clip_duration;
    logic [31:0]        start_offset;

    interp_t expected_q[$];

    // Floor of a + (b - a) * frac / 65536.
    function automatic logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                                logic [16:0] frac);
        longint p;
        p = (longint'(b) - longint'(a)) * longint'(frac);
        return 32'(longint'(a) + (p >>> 16));
    endfunction

    function automatic interp_t predict_query(logic [31:0] q);
        interp_t r;
        int n;
        int f;
        int pv;
        int nx;
        longint span;
        longint elapsed;
        longint fr;
        n = (frame_count == 0) ? 1 : (frame_count > MAX_KEYS) ? MAX_KEYS : int'(frame_count);
        f = n - 1;
        for (int i = 0; i < n; i++)
        begin
            if (trk_time[i] > q)
            begin
                f = i;
                break;
            end
        end
        pv = (f > 0) ? f - 1 : 0;
        nx = f;
        r.wrapped = 1'b0;
        if (f == n - 1 && trk_time[f] <= q)
        begin
            // Past the last key: run from the last key back to the loop start.
            r.wrapped = 1'b1;
            pv = f;
            nx = 0;
            if (start_offset != 0)
            begin
                nx = n - 1;
                for (int i = 0; i < n; i++)
                begin
                    if (trk_time[i] > start_offset)
                    begin
                        nx = i;
                        break;
                    end
                end
            end
            span = longint'(clip_duration) - longint'(trk_time[pv]);
        end
        else
        begin
            span = longint'(trk_time[nx]) - longint'(trk_time[pv]);
        end
        elapsed = longint'(q) - longint'(trk_time[pv]);
        if (span <= 0 || elapsed >= span)
            fr = FRAC_ONE;
        else if (elapsed <= 0)
            fr = 0;
        else
        begin
            fr = (elapsed << 16) / span;
            if (fr > FRAC_ONE)
                fr = FRAC_ONE;
        end
        r.frac = 17'(fr);
        r.prev_idx = 6'(pv);
        r.next_idx = 6'(nx);
        r.x = lerp(trk_x[pv], trk_x[nx], r.frac);
        r.y = lerp(trk_y[pv], trk_y[nx], r.frac);
        r.z = lerp(trk_z[pv], trk_z[nx], r.frac);
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        interp_t e;
        interp_t a;
        if (!rst_n)
        begin
            frame_count <= 7'd1;
            clip_duration <= '0;
            start_offset <= '0;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_FRAME_COUNT:   frame_count <= cfg_data[6:0];
                    REG_CLIP_DURATION: clip_duration <= cfg_data;
                    REG_START_OFFSET:  start_offset <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (cmd_t'(s_tuser) == CMD_WRITE)
                begin
                    if (s_tdata[5:0] < MAX_KEYS)
                    begin
                        trk_time[s_tdata[5:0]] = s_tdata[37:6];
                        trk_x[s_tdata[5:0]] = s_tdata[69:38];
                        trk_y[s_tdata[5:0]] = s_tdata[101:70];
                        trk_z[s_tdata[5:0]] = s_tdata[133:102];
                    end
                end
                else
                    expected_q.insert(expected_q.size(), predict_query(s_tdata[165:134]));
            end
            if (m_tvalid && m_tready)
            begin
                a.x = m_tdata[31:0];
                a.y = m_tdata[63:32];
                a.z = m_tdata[95:64];
                a.frac = m_tdata[112:96];
                a.prev_idx = m_tdata[118:113];
                a.next_idx = m_tdata[124:119];
                a.wrapped = m_tdata[125];
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result transfer with nothing expected", $realtime);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.frac !== e.frac ||
                        a.prev_idx !== e.prev_idx || a.next_idx !== e.next_idx ||
                        a.wrapped !== e.wrapped)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%t: mismatch exp x=%h y=%h z=%h frac=%h prev=%0d next=%0d ",
                                      "wrap=%b got x=%h y=%h z=%h frac=%h prev=%0d next=%0d wrap=%b"},
                                     $realtime, e.x, e.y, e.z, e.frac, e.prev_idx, e.next_idx,
                                     e.wrapped, a.x, a.y, a.z, a.frac, a.prev_idx, a.next_idx,
                                     a.wrapped);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the keyframe track interpolator testbench: stimulus, clock, reset and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kti_pkg::*;

    localparam int unsigned KEYS = 64;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // Fields from bit 0 up: key_index, key_time, value_x, value_y, value_z, query_time.
    logic [167:0] s_tdata;
    // Fields: cmd.
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // Fields from bit 0 up: out_x, out_y, out_z, fraction, prev_index, next_index, wrapped.
    logic [127:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    int fail_count;
    int pending;

    // While set, neither side idles, giving a long back-to-back stretch.
    logic no_gaps;

    // Key times as last written, used to aim queries, loop starts and rewrites near the keys.
    logic [31:0] key_time_copy [KEYS];

    keyframe_track_interpolator #(.MAX_KEYS(KEYS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kti_checker #(.MAX_KEYS(KEYS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The receiver stalls about 27 times in a hundred, except in the back-to-back stretch.
    always @(posedge clk)
        m_tready <= no_gaps || ($urandom_range(99) >= 27);

    // Drives one item and holds it until the transfer happens. A random gap before
    // it drops tvalid first.
    task automatic send(cmd_t cmd, logic [5:0] idx, logic [31:0] ktime, logic [31:0] vx,
                        logic [31:0] vy, logic [31:0] vz, logic [31:0] qtime);
        int gap;
        gap = (!no_gaps && $urandom_range(99) < 27) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, qtime, vz, vy, vx, ktime, idx};
        if (cmd == CMD_WRITE)
            key_time_copy[idx] = ktime;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_key(logic [5:0] idx, logic [31:0] ktime);
        send(CMD_WRITE, idx, ktime, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic query(logic [31:0] qtime);
        send(CMD_QUERY, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), qtime);
    endtask

    // Drops tvalid, lets the block drain until no result is pending, then idles.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // One register write; the write port is then left quiet before the task returns.
    task automatic set_reg(reg_idx_t idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Rewrites all keys with ascending times spaced by about the given stride.
    task automatic build_track(logic [31:0] stride, bit zero_first);
        for (int i = 0; i < KEYS; i++)
            write_key(6'(i), (zero_first && i == 0) ? 32'd0 :
                      32'(i) * stride + $urandom_range(0, stride - 1));
    endtask

    // A query aimed at a key: exactly on it, just around it, well above it, or anywhere.
    function automatic logic [31:0] pick_query_time();
        logic [31:0] t;
        t = key_time_copy[$urandom_range(KEYS - 1)];
        case ($urandom_range(4))
            0: return t;
            1: return t + $urandom_range(0, 255);
            2: return t - $urandom_range(0, 3);
            3: return $urandom();
            default: return t + $urandom_range(0, 32'h03FF_FFFF);
        endcase
    endfunction

    initial
    begin
        logic [31:0] strides [3];
        strides = '{32'd16, 32'h0001_0000, 32'h03FF_FFFF};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is written before any query can read it.
        build_track(32'h0001_0000, 1'b1);

        // Directed: extremes of values and times, wrap with and without a loop start.
        send(CMD_WRITE, 6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, '0);
        send(CMD_WRITE, 6'd1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0);
        query(32'd0);                 // Single key: always wraps.
        settle();
        set_reg(REG_FRAME_COUNT, 32'd2);
        set_reg(REG_CLIP_DURATION, 32'h0002_0000);
        query(32'd0);
        query(32'h0000_8000);         // Halfway between extremes.
        query(32'h0000_FFFF);
        query(32'h0001_0000);         // On the last key: wrap.
        query(32'h0001_8000);
        query(32'hFFFF_FFFF);         // Beyond the clip: saturates.
        settle();
        set_reg(REG_CLIP_DURATION, 32'd0);  // Non-positive wrap span.
        set_reg(REG_START_OFFSET, 32'hFFFF_FFFF);  // No key above the loop start.
        query(32'h0001_4000);
        settle();
        set_reg(REG_FRAME_COUNT, 32'd0);    // Acts as one key.
        query(32'h1234_5678);
        settle();
        set_reg(REG_FRAME_COUNT, 32'd127);  // Clamps to the full track.
        set_reg(REG_CLIP_DURATION, 32'hFFFF_FFFF);
        set_reg(REG_START_OFFSET, 32'h0000_8000);
        query(32'hFFFF_FFFF);
        query(32'h0010_0000);
        send(CMD_WRITE, 6'd5, 32'd0, 32'd1, 32'd2, 32'd3, '0);  // Unsorted times.
        query(32'h0004_8000);
        query(32'h0005_8000);

        // Random phases with varied settings.
        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            set_reg(REG_FRAME_COUNT, phase == 0 ? 32'd64 : phase == 1 ? 32'd1 :
                    phase == 2 ? 32'd0 : phase == 3 ? 32'd100 : $urandom_range(1, 64));
            set_reg(REG_CLIP_DURATION, phase == 4 ? 32'd0 : phase == 5 ? 32'hFFFF_FFFF :
                    $urandom());
            set_reg(REG_START_OFFSET, (phase % 3 == 0) ? 32'd0 : phase == 5 ? 32'hFFFF_FFFF :
                    (phase % 3 == 1) ? key_time_copy[$urandom_range(KEYS - 1)] : $urandom());
            if (phase % 4 == 0)
                build_track(strides[$urandom_range(2)], 1'($urandom_range(1)));
            no_gaps = (phase == 6);
            for (int k = 0; k < 28; k++)
            begin
                if (phase == 3 && k == 12)
                begin
                    // Hold off until the block has delivered everything.
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                if ($urandom_range(9) < 2)
                    write_key(6'($urandom()), $urandom_range(1) ? $urandom() :
                              key_time_copy[$urandom_range(KEYS - 1)]);
                else
                    query(pick_query_time());
            end
        end
        no_gaps = 1'b0;
        settle();

        if (fail_count == 0)
            $display("[keyframe_track_interpolator] OK");
        else
            $display("[keyframe_track_interpolator] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[keyframe_track_interpolator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/kti_pkg.sv
design/kti_cell.sv
design/kti_divider.sv
design/keyframe_track_interpolator.sv
dv/kti_checker.sv
dv/testbench.sv
